// ----- design/utf8d_pkg.sv -----
// Shared types and constants for the UTF-8 codepoint decoder.
// No dependencies; used by utf8d_decode, utf8d_emit and the top level.
package utf8d_pkg;

    localparam int unsigned CP_W = 21;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CP_W-1:0] QMARK_CP = CP_W'(63);

    // Lead-byte masks and patterns
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_PAT    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_PAT    = 8'hE0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_PAT    = 8'hF0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_PAT     = 8'h80;
    localparam logic [7:0] BITS2_MASK   = 8'h1F;
    localparam logic [7:0] BITS3_MASK   = 8'h0F;
    localparam logic [7:0] BITS4_MASK   = 8'h07;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

    // Results of one input byte: q_cnt '?' words, then optionally one final word.
    typedef struct packed {
        logic [1:0]      q_cnt;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
    } burst_t;

endpackage

// ----- design/utf8d_decode.sv -----
// Sequence state and single-pass decode of one registered input byte.
// Depends on utf8d_pkg (burst_t, byte constants).
module utf8d_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,       // byte leaves the input register
    input  logic [7:0]            data_byte,
    input  logic                  end_of_text,
    output utf8d_pkg::burst_t     burst
);

    logic [1:0]                 be_reg, be_next;
    logic [1:0]                 cs_reg, cs_next;
    logic [utf8d_pkg::CP_W-1:0] pv_reg, pv_next;

    logic                       seq_open, is_cont, complete;
    logic [1:0]                 cs_inc;
    logic [utf8d_pkg::CP_W-1:0] pv_shift;
    logic                       lead2, lead3, lead4, is_ascii;
    logic [1:0]                 need;
    logic [7:0]                 lead_bits;

    always_comb begin
        seq_open = (be_reg != 2'd0);
        is_cont  = ((data_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_PAT);
        cs_inc   = cs_reg + 2'd1;
        complete = (cs_inc >= be_reg);
        pv_shift = {pv_reg[utf8d_pkg::CP_W-7:0],
                    data_byte[5:0] & utf8d_pkg::PAYLOAD_MASK[5:0]};

        is_ascii = (data_byte < utf8d_pkg::ASCII_LIMIT);
        lead2    = ((data_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT);
        lead3    = ((data_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT);
        lead4    = ((data_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT);
        if (lead2) begin
            need      = 2'd1;
            lead_bits = data_byte & utf8d_pkg::BITS2_MASK;
        end else if (lead3) begin
            need      = 2'd2;
            lead_bits = data_byte & utf8d_pkg::BITS3_MASK;
        end else if (lead4) begin
            need      = 2'd3;
            lead_bits = data_byte & utf8d_pkg::BITS4_MASK;
        end else begin
            need      = 2'd0;
            lead_bits = 8'd0;
        end

        burst.q_cnt     = 2'd0;
        burst.has_final = 1'b0;
        burst.final_cp  = utf8d_pkg::QMARK_CP;
        be_next = 2'd0;
        cs_next = 2'd0;
        pv_next = pv_reg;

        if (seq_open && is_cont) begin
            if (complete) begin
                burst.has_final = 1'b1;
                burst.final_cp  = pv_shift;
            end else if (end_of_text) begin
                // truncated at end of text: lead plus every continuation taken
                burst.q_cnt = cs_inc + 2'd1;
            end else begin
                be_next = be_reg;
                cs_next = cs_inc;
                pv_next = pv_shift;
            end
        end else begin
            // broken sequence flushes first, then the byte decodes afresh
            burst.q_cnt = seq_open ? (cs_reg + 2'd1) : 2'd0;
            if (is_ascii) begin
                burst.has_final = 1'b1;
                burst.final_cp  = utf8d_pkg::CP_W'(data_byte);
            end else if (need == 2'd0 || end_of_text) begin
                burst.has_final = 1'b1;
            end else begin
                be_next = need;
                pv_next = utf8d_pkg::CP_W'(lead_bits);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            be_reg <= 2'd0;
            cs_reg <= 2'd0;
        end else if (fire) begin
            be_reg <= be_next;
            cs_reg <= cs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pv_reg <= pv_next;
        end
    end

    a_seen_below_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        (be_reg == 2'd0 && cs_reg == 2'd0) || (cs_reg < be_reg))
        else $error("continuation count out of range");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && end_of_text |=> be_reg == 2'd0)
        else $error("sequence left open after end of text");

    a_flush_only_on_break: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && burst.q_cnt != 2'd0 |-> seq_open)
        else $error("flush without open sequence");

endmodule

// ----- design/utf8d_emit.sv -----
// Result register: holds a byte's burst, one word per cycle while m_tready high.
// Depends on utf8d_pkg (burst_t, QMARK_CP).
module utf8d_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  utf8d_pkg::burst_t           burst,
    output logic                        load_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // [20:0] codepoint, [23:21] zero
    output logic                        m_tlast   // run_last
);

    logic [1:0]                 q_reg, q_next;
    logic                       fin_reg, fin_next;
    logic [utf8d_pkg::CP_W-1:0] cp_reg;
    logic                       take;

    always_comb begin
        m_tvalid   = (q_reg != 2'd0) || fin_reg;
        m_tdata    = {3'd0, (q_reg != 2'd0) ? utf8d_pkg::QMARK_CP : cp_reg};
        m_tlast    = (q_reg == 2'd1 && !fin_reg) || (q_reg == 2'd0 && fin_reg);
        take       = m_tvalid && m_tready;
        load_ready = !m_tvalid || (m_tready && m_tlast);

        q_next   = q_reg;
        fin_next = fin_reg;
        if (load) begin
            q_next   = burst.q_cnt;
            fin_next = burst.has_final;
        end else if (take) begin
            if (q_reg != 2'd0) begin
                q_next = q_reg - 2'd1;
            end else begin
                fin_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg   <= 2'd0;
            fin_reg <= 1'b0;
        end else begin
            q_reg   <= q_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg <= burst.final_cp;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> load_ready)
        else $error("burst loaded over pending words");

    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        take && m_tlast && !load |=> !m_tvalid)
        else $error("words left after run_last");

    a_flush_is_qmark: assert property (@(posedge aclk) disable iff (!aresetn)
        q_reg != 2'd0 |-> m_tdata[utf8d_pkg::CP_W-1:0] == utf8d_pkg::QMARK_CP)
        else $error("flush word is not '?'");

endmodule

// ----- design/utf8_codepoint_decoder_top.sv -----
// Top level of the UTF-8 codepoint decoder: input register, decode, result register.
// Depends on utf8d_pkg, utf8d_decode and utf8d_emit.
//
//  channel | dir | tdata                      | tlast
//  --------+-----+----------------------------+-------------
//  s_      | in  | [7:0] data_byte            | end_of_text
//  m_      | out | [20:0] codepoint, pad zero | run_last
//
// One byte per cycle while m_tready is high: input register -> decode ->
// result register, so a byte that gives at most one word passes at full rate.
// A byte that gives several words (up to 4, on broken or truncated sequences) holds
// the result register until the last word is out; the input register takes one more.
// aresetn (synchronous, active low) closes any open sequence and drops both valids.
// m_tready low stalls the result register and, behind it, the input register.
module utf8_codepoint_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] codepoint, [23:21] zero
    output logic        m_tlast    // run_last
);

    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              eot_reg;
    logic              load_ready;
    logic              advance;
    utf8d_pkg::burst_t burst;

    // A byte leaves the input register when the result register can take its burst.
    assign advance  = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || load_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
    end

    utf8d_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .data_byte   (byte_reg),
        .end_of_text (eot_reg),
        .burst       (burst)
    );

    // Loading an empty burst (sequence still open) leaves m_tvalid low.
    utf8d_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .burst      (burst),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for utf8_codepoint_decoder_top: byte stream in, codepoint words out.
// Depends on utf8d_pkg and the decoder RTL; a scoreboard class predicts each word.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS          = 480;  // rough byte budget, directed part included
    localparam int TAIL_ITEMS     = 80;   // last bytes run with no idling on either side
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 8;    // settle time after the last expected word

    // One expected output word
    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic                       last;
    } cp_word_t;

    // Scoreboard: tracks decoder state, queues the words each byte should give,
    // and checks output words against them in order.
    class codepoint_scoreboard;
        logic [1:0]                 need_cnt;   // continuations the open sequence needs
        logic [1:0]                 got_cnt;    // continuations taken so far
        logic [utf8d_pkg::CP_W-1:0] acc;        // bits gathered so far
        cp_word_t                   pending[$]; // words still owed by the block
        cp_word_t                   burst[$];   // words of the byte being decoded
        int                         fails;

        function new();
            clear_seq();
            fails = 0;
        endfunction

        function void clear_seq();
            need_cnt = '0;
            got_cnt  = '0;
            acc      = '0;
        endfunction

        // A byte never gives more than four words
        function void put(logic [utf8d_pkg::CP_W-1:0] cp);
            cp_word_t w;
            w.cp   = cp;
            w.last = 1'b0;
            if (burst.size() < 4)
                burst.insert(burst.size(), w);
        endfunction

        // '?' for the lead and each continuation taken, then close
        function void flush_open();
            repeat (int'(got_cnt) + 1) put(utf8d_pkg::QMARK_CP);
            clear_seq();
        endfunction

        // Decode a byte with no sequence open
        function void open_fresh(logic [7:0] b, logic eot);
            logic [1:0] n;
            logic [7:0] bits;
            n    = 2'd0;
            bits = '0;
            if (b < utf8d_pkg::ASCII_LIMIT) begin
                put(utf8d_pkg::CP_W'(b));
                return;
            end
            if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
                n    = 2'd1;
                bits = b & utf8d_pkg::BITS2_MASK;
            end else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
                n    = 2'd2;
                bits = b & utf8d_pkg::BITS3_MASK;
            end else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT) begin
                n    = 2'd3;
                bits = b & utf8d_pkg::BITS4_MASK;
            end
            // bad lead, or a good lead with nothing left to follow it
            if (n == 2'd0 || eot) begin
                put(utf8d_pkg::QMARK_CP);
            end else begin
                need_cnt = n;
                got_cnt  = 2'd0;
                acc      = utf8d_pkg::CP_W'(bits);
            end
        endfunction

        // Called for each byte the block accepts
        function void note_byte(logic [7:0] b, logic eot);
            burst.delete();
            if (need_cnt != 2'd0) begin
                if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_PAT) begin
                    acc     = {acc[utf8d_pkg::CP_W-7:0], 6'(b & utf8d_pkg::PAYLOAD_MASK)};
                    got_cnt = got_cnt + 2'd1;
                    if (got_cnt >= need_cnt) begin
                        put(acc);
                        clear_seq();
                    end else if (eot) begin
                        flush_open();
                    end
                end else begin
                    flush_open();
                    open_fresh(b, eot);
                end
            end else begin
                open_fresh(b, eot);
            end
            if (eot)
                clear_seq();
            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                pending.insert(pending.size(), burst[i]);
        endfunction

        // Called for each word the block hands over
        function void check_word(logic [23:0] data, logic last);
            cp_word_t want;
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: tdata 0x%06h tlast %0b", data, last);
                return;
            end
            want = pending.pop_front();
            if (data !== {3'b000, want.cp} || last !== want.last) begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: expected cp 0x%06h last %0b, got tdata 0x%06h tlast %0b",
                             want.cp, want.last, data, last);
            end
        endfunction
    endclass

    // DUT ports; every input known from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0; // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [20:0] codepoint, [23:21] zero
    logic        m_tlast;         // run_last

    codepoint_scoreboard cp_board = new();

    int sent_bytes = 0;
    bit send_gaps  = 1'b1;  // sender idles in bursts while set
    bit drain_gaps = 1'b1;  // receiver stalls in bursts while set
    bit quiet_tail = 1'b0;  // end of run: no idling anywhere
    int stall_left = 0;
    int idle_cycles = 0;

    utf8_codepoint_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: random stall bursts, with calm stretches where drain_gaps
    // is off. Exactly one NBA to m_tready per edge.
    always @(posedge aclk) begin
        if (quiet_tail || !drain_gaps) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 99) == 0)
            drain_gaps <= !drain_gaps;
    end

    // Output check: sampled at the edge, before any NBA of this step lands
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            cp_board.check_word(m_tdata, m_tlast);
    end

    // Watchdog: counts edges at which no word moves on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one byte. Optional idle burst first; valid stays high across
    // back-to-back bytes. Returns at the edge where the byte is taken.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (send_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        cp_board.note_byte(b, eot);
        sent_bytes++;
        if (sent_bytes >= ITEMS - TAIL_ITEMS)
            quiet_tail = 1'b1;
    endtask

    // Drop valid and hold off until the block owes nothing. The do-while
    // guarantees an edge passes before valid can be raised again.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (cp_board.pending.size() != 0);
    endtask

    // One random unit: mostly well-formed sequences with random payload,
    // some truncated sequences and raw noise. End marks land anywhere.
    task automatic send_random_unit();
        logic [7:0] unit[$];
        int kind;
        int need;
        int k;
        bit eot_end;
        kind = $urandom_range(0, 99);
        need = $urandom_range(1, 3);
        if (kind < 25) begin
            unit.insert(unit.size(), {1'b0, 7'($urandom)});
        end else if (kind < 90) begin
            if (kind < 80)          // complete sequence, length biased by kind
                need = (kind < 45) ? 1 : (kind < 65) ? 2 : 3;
            case (need)
                1:       unit.insert(unit.size(), {3'b110, 5'($urandom)});
                2:       unit.insert(unit.size(), {4'b1110, 4'($urandom)});
                default: unit.insert(unit.size(), {5'b11110, 3'($urandom)});
            endcase
            k = (kind < 80) ? need : $urandom_range(0, need - 1);
            repeat (k) unit.insert(unit.size(), {2'b10, 6'($urandom)});
            if (kind >= 80)         // whatever comes next breaks or finishes it
                unit.insert(unit.size(), 8'($urandom));
        end else begin
            unit.insert(unit.size(), 8'($urandom));
        end
        eot_end = ($urandom_range(0, 11) == 0);
        foreach (unit[i])
            send_byte(unit[i], (eot_end && i == unit.size() - 1) || $urandom_range(0, 40) == 0);
    endtask

    initial begin
        // synchronous reset, held low from the start
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // two-byte form
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        // three-byte form
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        // four-byte form, all payload bits set -> 0x1FFFFF
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // surrogate passes through undisturbed
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // bad leads: stray continuation and 0xF8..0xFF
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
        // broken sequence then ASCII decoded afresh
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        // broken four-byte form hit by a bad lead: four '?' from one byte
        send_byte(8'hF0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        // end of text inside a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // good lead carrying the end mark
        send_byte(8'hC3, 1'b1);

        // Sender holds off until everything owed has come out
        wait_drained();

        // Random part
        while (sent_bytes < ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                send_gaps = !send_gaps;
            send_random_unit();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (cp_board.fails == 0 && cp_board.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            if (cp_board.pending.size() != 0)
                $display("%0d expected words never arrived", cp_board.pending.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- utf8_codepoint_decoder_top.f -----
design/utf8d_pkg.sv
design/utf8d_decode.sv
design/utf8d_emit.sv
design/utf8_codepoint_decoder_top.sv
tb/tb_top.sv
